### design/blps_pkg.sv
// shared types and constants for the bresenham line pixel stepper
`default_nettype none
package blps_pkg;

    localparam int COORD_W       = 9;
    localparam int DELTA_W       = 10;
    localparam int ERR_W         = 12;
    localparam int WORD_W        = 5;
    localparam int BIT_W         = 4;
    localparam int COLOUR_W      = 16;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 32;

    localparam int DEF_SCREEN_WIDTH     = 320;
    localparam int DEF_SCREEN_HEIGHT    = 240;
    localparam int DEF_WORDS_PER_COLUMN = 15;

    localparam logic [COLOUR_W-1:0] ON_THRESHOLD = 16'h7777;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef struct packed {
        logic                    y_major;
        logic                    x_down;
        logic                    y_down;
    } dir_flags_t;

    typedef struct packed {
        logic [COORD_W-1:0]      cursor_x;
        logic [COORD_W-1:0]      cursor_y;
        logic [COORD_W-1:0]      target_x;
        logic [COORD_W-1:0]      target_y;
        logic signed [ERR_W-1:0] decision_error;
        logic [DELTA_W-1:0]      delta_major;
        logic [DELTA_W-1:0]      delta_minor;
        dir_flags_t              dir;
        logic                    line_active;
        logic                    stored_on;
    } line_state_t;

    typedef struct packed {
        logic [COORD_W-1:0]      start_x;
        logic [COORD_W-1:0]      start_y;
        logic [COORD_W-1:0]      end_x;
        logic [COORD_W-1:0]      end_y;
        logic [COLOUR_W-1:0]     colour;
    } load_t;

    typedef struct packed {
        logic [COORD_W-1:0]      pixel_x;
        logic [COORD_W-1:0]      pixel_y;
        logic                    pixel_on;
        logic                    in_bounds;
        logic [WORD_W-1:0]       word_column;
        logic [BIT_W-1:0]        bit_position;
        logic                    last;
    } pixel_t;

endpackage
`default_nettype wire

### design/blps_step.sv
// next-state and pixel logic for one load or step word
`default_nettype none
module blps_step #(
    parameter int SCREEN_WIDTH     = blps_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT    = blps_pkg::DEF_SCREEN_HEIGHT,
    parameter int WORDS_PER_COLUMN = blps_pkg::DEF_WORDS_PER_COLUMN
) (
    input  wire logic                  kind,
    input  wire blps_pkg::load_t       load,
    input  wire blps_pkg::line_state_t state,
    output blps_pkg::line_state_t      state_next,
    output logic                       res_valid,
    output blps_pkg::pixel_t           pixel
);

    localparam int CW = blps_pkg::COORD_W;
    localparam int DW = blps_pkg::DELTA_W;
    localparam int EW = blps_pkg::ERR_W;

    logic [CW-1:0]          dx;
    logic [CW-1:0]          dy;
    logic                   y_major_ld;
    logic [DW-1:0]          dmaj_ld;
    logic [DW-1:0]          dmin_ld;
    logic signed [EW:0]     err_ld;
    logic                   last;
    logic                   x_ok;
    logic                   y_ok;
    logic [CW-1:0]          flip;
    logic [blps_pkg::WORD_W-1:0] word;
    logic                   w_ok;
    logic                   inb;
    logic                   minor_step;
    logic signed [EW:0]     err_step;
    logic [CW-1:0]          x_stepped;
    logic [CW-1:0]          y_stepped;

    always_comb
    begin
        dx = (load.end_x >= load.start_x) ? load.end_x - load.start_x
                                          : load.start_x - load.end_x;
        dy = (load.end_y >= load.start_y) ? load.end_y - load.start_y
                                          : load.start_y - load.end_y;
        y_major_ld = !(dx > dy);
        dmaj_ld = y_major_ld ? {1'b0, dy} : {1'b0, dx};
        dmin_ld = y_major_ld ? {1'b0, dx} : {1'b0, dy};
        err_ld = $signed({2'b00, dmin_ld, 1'b0}) - $signed({3'b000, dmaj_ld});
    end

    always_comb
    begin
        last = (state.cursor_x == state.target_x) && (state.cursor_y == state.target_y);
        x_ok = {1'b0, state.cursor_x} < (CW+1)'(SCREEN_WIDTH);
        y_ok = {1'b0, state.cursor_y} < (CW+1)'(SCREEN_HEIGHT);
        flip = CW'(SCREEN_HEIGHT - 1) - state.cursor_y;
        word = flip[CW-1:4];
        w_ok = {1'b0, word} < (blps_pkg::WORD_W+1)'(WORDS_PER_COLUMN);
        inb  = x_ok && y_ok && w_ok;

        pixel.pixel_x      = state.cursor_x;
        pixel.pixel_y      = state.cursor_y;
        pixel.pixel_on     = state.stored_on;
        pixel.in_bounds    = inb;
        pixel.word_column  = inb ? word : '0;
        pixel.bit_position = inb ? flip[3:0] : '0;
        pixel.last         = last;
    end

    always_comb
    begin
        minor_step = !state.decision_error[EW-1] && (state.decision_error != '0);
        err_step = $signed({state.decision_error[EW-1], state.decision_error})
                 + $signed({2'b00, state.delta_minor, 1'b0})
                 - (minor_step ? $signed({2'b00, state.delta_major, 1'b0}) : $signed((EW+1)'(0)));
        x_stepped = state.dir.x_down ? state.cursor_x - CW'(1) : state.cursor_x + CW'(1);
        y_stepped = state.dir.y_down ? state.cursor_y - CW'(1) : state.cursor_y + CW'(1);
    end

    always_comb
    begin
        state_next = state;
        res_valid  = 1'b0;
        if (kind == blps_pkg::KIND_LOAD)
        begin
            state_next.cursor_x       = load.start_x;
            state_next.cursor_y       = load.start_y;
            state_next.target_x       = load.end_x;
            state_next.target_y       = load.end_y;
            state_next.decision_error = err_ld[EW-1:0];
            state_next.delta_major    = dmaj_ld;
            state_next.delta_minor    = dmin_ld;
            state_next.dir.y_major    = y_major_ld;
            state_next.dir.x_down     = load.end_x < load.start_x;
            state_next.dir.y_down     = load.end_y < load.start_y;
            state_next.line_active    = 1'b1;
            state_next.stored_on      = load.colour >= blps_pkg::ON_THRESHOLD;
        end
        else if (state.line_active)
        begin
            res_valid = 1'b1;
            if (last)
            begin
                state_next.line_active = 1'b0;
            end
            else
            begin
                if (state.dir.y_major)
                begin
                    state_next.cursor_y = y_stepped;
                    if (minor_step)
                    begin
                        state_next.cursor_x = x_stepped;
                    end
                end
                else
                begin
                    state_next.cursor_x = x_stepped;
                    if (minor_step)
                    begin
                        state_next.cursor_y = y_stepped;
                    end
                end
                state_next.decision_error = err_step[EW-1:0];
            end
        end
    end

endmodule
`default_nettype wire

### design/bresenham_line_pixel_stepper_top.sv
// top level of the bresenham line pixel stepper
//
// input channel s_axis: one word per cycle; tuser is the kind bit, 0 loads a
// line (end points and colour in tdata, no pixel produced), 1 asks for the
// next pixel of the current line (tdata ignored, no pixel if no line is live)
// output channel m_axis: one pixel word per step, tlast marks the end point
// a pixel appears on m_axis in the cycle after its step word is taken
// throughput: one word per cycle, set by the single state register update
// the state and the result register are updated in the same cycle, so the
// next word is taken in the same cycle as the held pixel leaves
// when the receiver stalls with a pixel held, s_axis_tready drops until the
// held pixel is taken; a load word is also held off then
// after reset no line is live, the output register is empty and
// s_axis_tready is high
`default_nettype none
module bresenham_line_pixel_stepper_top #(
    parameter int SCREEN_WIDTH     = blps_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT    = blps_pkg::DEF_SCREEN_HEIGHT,
    parameter int WORDS_PER_COLUMN = blps_pkg::DEF_WORDS_PER_COLUMN
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // start_x, start_y, end_x, end_y, colour, zero pad
    input  wire logic [blps_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind
    input  wire logic                             s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // pixel_x, pixel_y, pixel_on, in_bounds, word_column, bit_position, zero pad
    output logic [blps_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                  m_axis_tlast
);

    blps_pkg::line_state_t state_reg;
    blps_pkg::line_state_t state_next;
    blps_pkg::load_t       load;
    blps_pkg::pixel_t      pixel;
    blps_pkg::pixel_t      pixel_reg;
    logic                  res_valid;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  accept;

    assign load.start_x = s_axis_tdata[8:0];
    assign load.start_y = s_axis_tdata[17:9];
    assign load.end_x   = s_axis_tdata[26:18];
    assign load.end_y   = s_axis_tdata[35:27];
    assign load.colour  = s_axis_tdata[51:36];

    blps_step #(
        .SCREEN_WIDTH     (SCREEN_WIDTH),
        .SCREEN_HEIGHT    (SCREEN_HEIGHT),
        .WORDS_PER_COLUMN (WORDS_PER_COLUMN)
    ) u_step (
        .kind       (s_axis_tuser),
        .load       (load),
        .state      (state_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .pixel      (pixel)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            pixel_reg <= pixel;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = pixel_reg.last;
    assign m_axis_tdata  = {3'b000, pixel_reg.bit_position, pixel_reg.word_column,
                            pixel_reg.in_bounds, pixel_reg.pixel_on,
                            pixel_reg.pixel_y, pixel_reg.pixel_x};

endmodule
`default_nettype wire

### design/blps_checker.sv
// port-level assertions for the bresenham line pixel stepper and their bind
`default_nettype none
module blps_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [blps_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tlast
);

    // stalled pixel stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("pixel word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("pixel word changed while stalled");

    // empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held off with empty output");

    // out of bounds pixels carry a zero word and bit
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[19] |-> m_axis_tdata[28:20] == 9'd0)
        else $error("out of bounds pixel has nonzero word or bit");

    // a load word never produces a pixel
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == blps_pkg::KIND_LOAD)
        && (!m_axis_tvalid || m_axis_tready) |=> !m_axis_tvalid)
        else $error("pixel produced by a load word");

endmodule

bind bresenham_line_pixel_stepper_top blps_checker u_blps_checker (.*);
`default_nettype wire
